@@ design/pru_pkg.sv @@
// Shared types and constants for the PNG row unfilter.
package pru_pkg;

  localparam int COLUMNS_W       = 13;
  localparam int MAX_COLUMNS_DEF = 4096;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter;
  } out_item_t;

endpackage

@@ design/pru_row_store.sv @@
// Prior-row byte memory with one write port and one registered read port.
module pru_row_store #(
  parameter int DEPTH = pru_pkg::MAX_COLUMNS_DEF
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [7:0]                                 wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [7:0]                                 rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/png_row_unfilter.sv @@
// PNG row unfilter: one byte per pixel, None/Sub/Up/Average/Paeth reconstruction.
// An accepted data item is registered in stage one, then in the output register that drives out_valid.
// Throughput: one item per cycle while out_stall does not hold the output; filter-type items produce no output item.
// The prior row lives in a single-port-write, registered-read memory; a
// written-prefix count makes unwritten entries read as zero, so no clear pass.
// Synchronous active-low reset clears control state; columns resets to 1.
module png_row_unfilter #(
  parameter int MAX_COLUMNS = pru_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pru_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pru_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [pru_pkg::COLUMNS_W-1:0]   cfg_wdata
);

  import pru_pkg::*;

  localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int EW = ((CW > COLUMNS_W) ? CW : COLUMNS_W) + 1;

  // front-end control state
  logic                 await_r, await_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [CW-1:0]        hw_r, hw_nxt;
  filter_t              filt_r, filt_nxt;
  logic                 bad_r, bad_nxt;
  logic [COLUMNS_W-1:0] columns_r, columns_nxt;

  // stage one
  logic          s1_v_r, s1_v_nxt;
  logic [7:0]    s1_data_r;
  filter_t       s1_filt_r;
  logic          s1_bad_r, s1_first_r, s1_end_r, s1_bvalid_r, s1_byp_r;
  logic [7:0]    s1_bypd_r;
  logic [IW-1:0] s1_idx_r;

  // stage two state
  logic [7:0] left_r, ul_r;

  // output register
  logic      out_v_r, out_v_nxt;
  out_item_t out_item_r;

  logic          in_acc, out_free, s1_adv, awaiting, data_acc;
  logic [IW-1:0] rd_idx;
  logic [EW-1:0] cfg_ext, eff_cols, col_inc;
  logic          row_done, byp_hit;
  logic [7:0]    rd_data;

  logic [7:0] a_v, b_v, c_v, pred, result;
  logic [7:0] pa, pb;
  logic [8:0] ab_sum, c_dbl, pc, pa_w, pb_w;

  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign awaiting = await_r || in_item.stream_start;
  assign data_acc = in_acc && !awaiting;

  assign rd_idx   = IW'(col_r);
  assign cfg_ext  = EW'(columns_r);
  assign eff_cols = (cfg_ext == '0) ? EW'(1) :
                    (cfg_ext > EW'(MAX_COLUMNS)) ? EW'(MAX_COLUMNS) : cfg_ext;
  assign col_inc  = EW'(col_r) + EW'(1);
  assign row_done = col_inc >= eff_cols;
  assign byp_hit  = s1_v_r && (s1_idx_r == rd_idx);

  always_comb begin
    await_nxt   = await_r;
    col_nxt     = col_r;
    hw_nxt      = hw_r;
    filt_nxt    = filt_r;
    bad_nxt     = bad_r;
    columns_nxt = cfg_we ? cfg_wdata : columns_r;
    if (in_acc) begin
      if (awaiting) begin
        bad_nxt   = in_item.data_byte > 8'd4;
        filt_nxt  = bad_nxt ? FILT_NONE : filter_t'(in_item.data_byte[2:0]);
        col_nxt   = '0;
        await_nxt = 1'b0;
        if (in_item.stream_start) begin
          hw_nxt = '0;
        end
      end else begin
        if (CW'(col_inc) > hw_r) begin
          hw_nxt = CW'(col_inc);
        end
        col_nxt   = row_done ? '0 : CW'(col_inc);
        await_nxt = row_done;
      end
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    if (data_acc) begin
      s1_v_nxt = 1'b1;
    end
    out_v_nxt = out_v_r;
    if (out_free) begin
      out_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r   <= 1'b1;
      col_r     <= '0;
      hw_r      <= '0;
      filt_r    <= FILT_NONE;
      bad_r     <= 1'b0;
      columns_r <= COLUMNS_W'(1);
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      await_r   <= await_nxt;
      col_r     <= col_nxt;
      hw_r      <= hw_nxt;
      filt_r    <= filt_nxt;
      bad_r     <= bad_nxt;
      columns_r <= columns_nxt;
      s1_v_r    <= s1_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (data_acc) begin
      s1_data_r   <= in_item.data_byte;
      s1_filt_r   <= filt_r;
      s1_bad_r    <= bad_r;
      s1_first_r  <= (col_r == '0);
      s1_end_r    <= row_done;
      s1_idx_r    <= rd_idx;
      s1_bvalid_r <= col_r < hw_r;
      s1_byp_r    <= byp_hit;
      s1_bypd_r   <= result;
    end
    if (s1_adv) begin
      left_r <= result;
      ul_r   <= b_v;
    end
    if (out_free) begin
      out_item_r.pixel_byte <= result;
      out_item_r.row_end    <= s1_end_r;
      out_item_r.bad_filter <= s1_bad_r;
    end
  end

  pru_row_store #(
    .DEPTH(MAX_COLUMNS)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_idx_r),
    .wr_data (result),
    .rd_en   (data_acc),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  always_comb begin
    a_v    = s1_first_r ? 8'd0 : left_r;
    c_v    = s1_first_r ? 8'd0 : ul_r;
    b_v    = !s1_bvalid_r ? 8'd0 : (s1_byp_r ? s1_bypd_r : rd_data);
    pa     = (b_v >= c_v) ? (b_v - c_v) : (c_v - b_v);
    pb     = (a_v >= c_v) ? (a_v - c_v) : (c_v - a_v);
    ab_sum = {1'b0, a_v} + {1'b0, b_v};
    c_dbl  = {c_v, 1'b0};
    pc     = (ab_sum >= c_dbl) ? (ab_sum - c_dbl) : (c_dbl - ab_sum);
    pa_w   = {1'b0, pa};
    pb_w   = {1'b0, pb};
    case (s1_filt_r)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a_v;
      FILT_UP:    pred = b_v;
      FILT_AVG:   pred = ab_sum[8:1];
      FILT_PAETH: begin
        if (pa_w <= pb_w && pa_w <= pc) begin
          pred = a_v;
        end else if (pb_w <= pc) begin
          pred = b_v;
        end else begin
          pred = c_v;
        end
      end
      default:    pred = 8'd0;
    endcase
    result = pred + s1_data_r;
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule
